@@ sv/aabb_pkg.sv @@
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types and constants for the all-pairs box overlap block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

    localparam int MAX_COLLIDERS = 32;
    localparam int FRAC_BITS     = 16;
    localparam int IDX_W         = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
    localparam int CNT_W         = $clog2(MAX_COLLIDERS + 1);

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLLIDERS);

    typedef struct packed {
        logic               first_of_frame;
        logic [15:0]        object_id;
        logic signed [31:0] box_left;
        logic signed [31:0] box_right;
        logic signed [31:0] box_top;
        logic signed [31:0] box_bottom;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [15:0] earlier_id;
        logic [15:0] current_id;
        logic        not_stored;
        logic        last;
    } t_out;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] top;
        logic signed [31:0] bottom;
        logic [15:0]        id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

@@ sv/aabb_all_pairs_overlap.sv @@
// ----------------------------------------------------------------------------
// aabb_all_pairs_overlap
// tests each new collider against all boxes stored this frame, then stores it unless the table is full
// flow: one collider at a time, next accepted once its scan over n stored boxes (n up to 32)
// ends, read through the single read port of the box memory; output stalls pause the scan
// reset: synchronous active low, empties the table and drops pending results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_all_pairs_overlap (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire aabb_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output aabb_pkg::t_out      o_out_data
);

    aabb_pkg::t_state                  r_state;
    aabb_pkg::t_state                  n_state;
    aabb_pkg::t_in                     r_item;
    logic [aabb_pkg::CNT_W-1:0]        r_count;
    logic [aabb_pkg::CNT_W-1:0]        r_rd_idx;
    logic                              r_q_vld;
    logic                              r_pend_vld;
    logic [15:0]                       r_pend_id;
    logic                              r_full;
    logic                              r_out_vld;
    aabb_pkg::t_out                    r_out;

    logic signed [31:0]                w_left;
    logic signed [31:0]                w_right;
    logic signed [31:0]                w_top;
    logic signed [31:0]                w_bottom;
    aabb_pkg::t_entry                  w_q;
    aabb_pkg::t_entry                  w_wentry;
    logic [aabb_pkg::ENTRY_W-1:0]      w_rdata;

    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_scan;
    logic                              w_rd_en;
    logic                              w_finish;
    logic                              w_overlap;
    logic                              w_emit;
    logic                              w_we;
    aabb_pkg::t_out                    w_res;

    aabb_edge u_edge_l (
        .i_clk  (i_clk),
        .i_off  (r_item.box_left),
        .i_scl  (r_item.scale_x),
        .i_pos  (r_item.pos_x),
        .o_edge (w_left)
    );

    aabb_edge u_edge_r (
        .i_clk  (i_clk),
        .i_off  (r_item.box_right),
        .i_scl  (r_item.scale_x),
        .i_pos  (r_item.pos_x),
        .o_edge (w_right)
    );

    aabb_edge u_edge_t (
        .i_clk  (i_clk),
        .i_off  (r_item.box_top),
        .i_scl  (r_item.scale_y),
        .i_pos  (r_item.pos_y),
        .o_edge (w_top)
    );

    aabb_edge u_edge_b (
        .i_clk  (i_clk),
        .i_off  (r_item.box_bottom),
        .i_scl  (r_item.scale_y),
        .i_pos  (r_item.pos_y),
        .o_edge (w_bottom)
    );

    always_comb begin
        w_wentry.left   = w_left;
        w_wentry.right  = w_right;
        w_wentry.top    = w_top;
        w_wentry.bottom = w_bottom;
        w_wentry.id     = r_item.object_id;
    end

    aabb_ram #(
        .WIDTH (aabb_pkg::ENTRY_W),
        .DEPTH (aabb_pkg::MAX_COLLIDERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[aabb_pkg::IDX_W-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[aabb_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_q = w_rdata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aabb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = aabb_pkg::ST_MUL;
                end
            end
            aabb_pkg::ST_MUL: begin
                n_state = aabb_pkg::ST_SUM;
            end
            aabb_pkg::ST_SUM: begin
                n_state = aabb_pkg::ST_SCAN;
            end
            aabb_pkg::ST_SCAN: begin
                if (w_finish) begin
                    n_state = aabb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aabb_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        w_accept   = i_in_valid && (r_state == aabb_pkg::ST_IDLE);
        w_out_free = !r_out_vld || !i_out_stall;
        w_scan     = (r_state == aabb_pkg::ST_SCAN) && w_out_free;
        w_rd_en    = w_scan && (r_rd_idx != r_count);
        w_finish   = w_scan && !r_q_vld && (r_rd_idx == r_count);
        w_overlap  = !((w_q.left > w_right) || (w_left > w_q.right) ||
                       (w_q.bottom > w_top) || (w_bottom > w_q.top));
        w_we       = w_finish && !r_full;

        w_res.current_id = r_item.object_id;
        w_res.not_stored = r_full;
        if (w_finish) begin
            w_emit           = 1'b1;
            w_res.hit        = r_pend_vld;
            w_res.earlier_id = r_pend_vld ? r_pend_id : 16'd0;
            w_res.last       = 1'b1;
        end else begin
            w_emit           = w_scan && r_q_vld && w_overlap && r_pend_vld;
            w_res.hit        = 1'b1;
            w_res.earlier_id = r_pend_id;
            w_res.last       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aabb_pkg::ST_IDLE;
            r_count    <= '0;
            r_rd_idx   <= '0;
            r_q_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_full     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_in_data.first_of_frame) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + aabb_pkg::CNT_ONE;
            end
            if (r_state == aabb_pkg::ST_MUL) begin
                r_rd_idx   <= '0;
                r_q_vld    <= 1'b0;
                r_pend_vld <= 1'b0;
                r_full     <= (r_count == aabb_pkg::CNT_MAX);
            end else if (w_scan) begin
                r_q_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_rd_idx <= r_rd_idx + aabb_pkg::CNT_ONE;
                end
                if (r_q_vld && w_overlap) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (w_scan && r_q_vld && w_overlap) begin
            r_pend_id <= w_q.id;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_in_stall  = (r_state != aabb_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= aabb_pkg::CNT_MAX)
        else $error("stored box count above table size");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aabb_pkg::ST_SCAN) |-> (r_rd_idx <= r_count))
        else $error("scan read index past stored boxes");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_count != aabb_pkg::CNT_MAX))
        else $error("box written into a full table");

    a_read_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> r_q_vld)
        else $error("memory read not followed by compare");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !w_emit)
        else $error("result overwrote a stalled beat");
`endif

endmodule

`default_nettype wire

@@ sv/aabb_ram.sv @@
// ----------------------------------------------------------------------------
// aabb_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/aabb_edge.sv @@
// ----------------------------------------------------------------------------
// aabb_edge
// world edge: offset times scale, floor shift, plus position, saturated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_edge (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_off,
    input  wire logic signed [31:0] i_scl,
    input  wire logic signed [31:0] i_pos,
    output logic signed [31:0]      o_edge
);

    logic signed [63:0] r_prod;
    logic signed [31:0] r_edge;
    logic signed [63:0] w_shift;
    logic signed [63:0] w_sum;
    logic signed [31:0] n_edge;

    always_ff @(posedge i_clk) begin
        r_prod <= i_off * i_scl;
        r_edge <= n_edge;
    end

    always_comb begin
        w_shift = r_prod >>> aabb_pkg::FRAC_BITS;
        w_sum   = w_shift + $signed({{32{i_pos[31]}}, i_pos});
        if ((&w_sum[63:31]) || !(|w_sum[63:31])) begin
            n_edge = w_sum[31:0];
        end else if (w_sum[63]) begin
            n_edge = 32'sh8000_0000;
        end else begin
            n_edge = 32'sh7fff_ffff;
        end
    end

    assign o_edge = r_edge;

endmodule

`default_nettype wire
